>>> hdl/gdsd_pkg.sv
// Shared constants and calendar tables for the Gregorian date span block.
// Used by gdsd_day_number and gregorian_date_span_days; depends on nothing.
`default_nettype none

package gdsd_pkg;

    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned COUNT_W  = 22;
    localparam int unsigned DAYNUM_W = 23;

    localparam logic [YEAR_W-1:0] MAX_YEAR = 14'd9999;

    // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every 14-bit x
    localparam int unsigned RECIP_SHIFT = 19;
    localparam int unsigned PROD_W      = 27;
    localparam logic [PROD_W-1:0] RECIP_100 = 27'd5243;

    localparam logic [8:0]         DAYS_PER_YEAR = 9'd365;
    localparam logic [MONTH_W-1:0] MONTH_JAN     = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC     = 4'd12;
    localparam logic [DAY_W-1:0]   FEB_COMMON    = 5'd28;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = 22'd4194303;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = 22'd3652059;

    typedef struct packed {
        logic st1;
        logic st2;
        logic st3;
    } gdsd_adv_t;

    // Days before the first of the month in a common year.
    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
        logic [8:0] r;
        case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // Month length in a common year.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] r;
        case (m)
            4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
            4'd2:                    r = 5'd28;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:      r = 5'd31;
            default:                 r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/gregorian_date_span_days.sv
// Top level of the Gregorian date span block: two day number units and the
// difference stage, with per-stage handshake. Depends on gdsd_pkg, gdsd_day_number.
//
//  channel  dir  tdata                                        tuser
//  s_axis   in   two dates and include_end (47 bits in 48)    -
//  m_axis   out  day_count (22 bits in 24)                    date_error
//
// An accepted beat passes the day number stages and the output register; one beat
// per cycle is sustained while the output is not stalled. The stage depth is set
// by the divide-by-100 reciprocal multiplies. Reset clears the valid bits only. A
// stalled output holds its stage; earlier stages keep filling empty slots behind it.
`default_nettype none

module gregorian_date_span_days
    import gdsd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // start_year[13:0], start_month[17:14], start_day[22:18], end_year[36:23],
    // end_month[40:37], end_day[45:41], include_end[46], zero[47]
    input  wire logic [47:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // day_count[21:0], zero[23:22]
    output logic      [23:0] m_axis_tdata,
    // date_error[0]
    output logic             m_axis_tuser
);

    logic v1_reg, v2_reg, v3_reg, vout_reg;
    logic en1, en2, en3, en_out;
    gdsd_adv_t adv;

    // a stage loads when it is empty or its contents move on
    always_comb
    begin
        en_out  = !vout_reg || m_axis_tready;
        en3     = !v3_reg || en_out;
        en2     = !v2_reg || en3;
        en1     = !v1_reg || en2;
        adv.st1 = en1;
        adv.st2 = en2;
        adv.st3 = en3;
    end

    assign s_axis_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= s_axis_tvalid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en_out)
                vout_reg <= v3_reg;
        end
    end

    logic [DAYNUM_W-1:0] start_dn, end_dn;
    logic                start_ok, end_ok;

    gdsd_day_number u_start (
        .clk     (clk),
        .adv     (adv),
        .year    (s_axis_tdata[13:0]),
        .month   (s_axis_tdata[17:14]),
        .day     (s_axis_tdata[22:18]),
        .day_num (start_dn),
        .date_ok (start_ok)
    );

    gdsd_day_number u_end (
        .clk     (clk),
        .adv     (adv),
        .year    (s_axis_tdata[36:23]),
        .month   (s_axis_tdata[40:37]),
        .day     (s_axis_tdata[45:41]),
        .day_num (end_dn),
        .date_ok (end_ok)
    );

    logic inc1_reg, inc2_reg, inc3_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
            inc1_reg <= s_axis_tdata[46];
        if (en2)
            inc2_reg <= inc1_reg;
        if (en3)
            inc3_reg <= inc2_reg;
    end

    // output stage: difference, clamp at zero, add end day, saturate, zero on a date error
    logic [DAYNUM_W-1:0] diff;
    logic [DAYNUM_W:0]   total;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                err_reg,   err_next;

    always_comb
    begin
        diff     = (end_dn > start_dn) ? end_dn - start_dn : '0;
        total    = {1'b0, diff} + (DAYNUM_W+1)'(inc3_reg);
        err_next = !(start_ok && end_ok);
        if (err_next)
            count_next = '0;
        else if (total > (DAYNUM_W+1)'(COUNT_MAX))
            count_next = COUNT_MAX;
        else
            count_next = total[COUNT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            count_reg <= count_next;
            err_reg   <= err_next;
        end
    end

    assign m_axis_tvalid = vout_reg;
    assign m_axis_tdata  = {2'b00, count_reg};
    assign m_axis_tuser  = err_reg;

    // error beats carry no count
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[21:0] == '0)
        else $error("error beat with nonzero day count");

    // valid dates never span more than the calendar range
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[21:0] <= COUNT_LIMIT)
        else $error("day count beyond calendar range");

    // a full last stage that may advance shows up at the output
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && en_out |=> m_axis_tvalid)
        else $error("beat lost between last stage and output");

endmodule

`default_nettype wire

>>> hdl/gdsd_day_number.sv
// Three-stage day number unit: converts one date to its day number
// (0001-01-01 is day 1) and checks it. Depends on gdsd_pkg.
`default_nettype none

module gdsd_day_number
    import gdsd_pkg::*;
(
    input  wire logic                clk,
    input  wire gdsd_adv_t           adv,
    input  wire logic [YEAR_W-1:0]   year,
    input  wire logic [MONTH_W-1:0]  month,
    input  wire logic [DAY_W-1:0]    day,
    output logic      [DAYNUM_W-1:0] day_num,
    output logic                     date_ok
);

    // stage 1: divides by 100 through reciprocal multiplies, 365 * (year - 1)
    logic [YEAR_W-1:0]   p_s1;
    logic [PROD_W-1:0]   prod_y;
    logic [PROD_W-1:0]   prod_p;
    logic [PROD_W-1:0]   prod_p4;

    logic [YEAR_W-1:0]   year_s1_reg,  year_s1_next;
    logic [YEAR_W-1:0]   p_s1_reg,     p_s1_next;
    logic [MONTH_W-1:0]  month_s1_reg, month_s1_next;
    logic [DAY_W-1:0]    day_s1_reg,   day_s1_next;
    logic [DAYNUM_W-1:0] p365_s1_reg,  p365_s1_next;
    logic [7:0]          qy_s1_reg,    qy_s1_next;
    logic [7:0]          qp_s1_reg,    qp_s1_next;
    logic [5:0]          qp4_s1_reg,   qp4_s1_next;
    logic                yok_s1_reg,   yok_s1_next;

    always_comb
    begin
        p_s1          = year - 14'd1;
        prod_y        = PROD_W'(year) * RECIP_100;
        prod_p        = PROD_W'(p_s1) * RECIP_100;
        prod_p4       = PROD_W'(p_s1 >> 2) * RECIP_100;
        year_s1_next  = year;
        p_s1_next     = p_s1;
        month_s1_next = month;
        day_s1_next   = day;
        p365_s1_next  = DAYNUM_W'(p_s1) * DAYNUM_W'(DAYS_PER_YEAR);
        qy_s1_next    = prod_y[RECIP_SHIFT+7:RECIP_SHIFT];
        qp_s1_next    = prod_p[RECIP_SHIFT+7:RECIP_SHIFT];
        qp4_s1_next   = prod_p4[RECIP_SHIFT+5:RECIP_SHIFT];
        yok_s1_next   = (year != '0) && (year <= MAX_YEAR);
    end

    // stage 2: leap rule, year part of the day number, month offset, checks
    logic [YEAR_W-1:0]   rem100;
    logic                leap;
    logic [DAY_W-1:0]    len;

    logic [DAYNUM_W-1:0] nyear_s2_reg, nyear_s2_next;
    logic [8:0]          mofs_s2_reg,  mofs_s2_next;
    logic [DAY_W-1:0]    day_s2_reg,   day_s2_next;
    logic                ok_s2_reg,    ok_s2_next;

    always_comb
    begin
        rem100 = year_s1_reg - YEAR_W'(qy_s1_reg) * 14'd100;
        // divisible by 400 when divisible by 100 and the quotient by 4
        leap   = (year_s1_reg[1:0] == 2'b00) &&
                 ((rem100 != '0) || (qy_s1_reg[1:0] == 2'b00));
        len    = (month_s1_reg == MONTH_FEB) ? FEB_COMMON + DAY_W'(leap)
                                             : month_len(month_s1_reg);
        nyear_s2_next = p365_s1_reg + DAYNUM_W'(p_s1_reg >> 2)
                        - DAYNUM_W'(qp_s1_reg) + DAYNUM_W'(qp4_s1_reg);
        mofs_s2_next  = days_before(month_s1_reg)
                        + 9'((month_s1_reg > MONTH_FEB) && leap);
        day_s2_next   = day_s1_reg;
        ok_s2_next    = yok_s1_reg && (month_s1_reg >= MONTH_JAN) &&
                        (month_s1_reg <= MONTH_DEC) && (day_s1_reg != '0) &&
                        (day_s1_reg <= len);
    end

    // stage 3: sum the parts
    logic [DAYNUM_W-1:0] dn_s3_reg, dn_s3_next;
    logic                ok_s3_reg, ok_s3_next;

    always_comb
    begin
        dn_s3_next = nyear_s2_reg + DAYNUM_W'(mofs_s2_reg) + DAYNUM_W'(day_s2_reg);
        ok_s3_next = ok_s2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv.st1)
        begin
            year_s1_reg  <= year_s1_next;
            p_s1_reg     <= p_s1_next;
            month_s1_reg <= month_s1_next;
            day_s1_reg   <= day_s1_next;
            p365_s1_reg  <= p365_s1_next;
            qy_s1_reg    <= qy_s1_next;
            qp_s1_reg    <= qp_s1_next;
            qp4_s1_reg   <= qp4_s1_next;
            yok_s1_reg   <= yok_s1_next;
        end
        if (adv.st2)
        begin
            nyear_s2_reg <= nyear_s2_next;
            mofs_s2_reg  <= mofs_s2_next;
            day_s2_reg   <= day_s2_next;
            ok_s2_reg    <= ok_s2_next;
        end
        if (adv.st3)
        begin
            dn_s3_reg <= dn_s3_next;
            ok_s3_reg <= ok_s3_next;
        end
    end

    assign day_num = dn_s3_reg;
    assign date_ok = ok_s3_reg;

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for gregorian_date_span_days: directed and random date
// pairs are streamed in, and each result beat is checked against a day-number predictor.
// Depends on gdsd_pkg and the RTL of gregorian_date_span_days.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gdsd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 225;

    typedef struct packed {
        logic [YEAR_W-1:0]  start_year;
        logic [MONTH_W-1:0] start_month;
        logic [DAY_W-1:0]   start_day;
        logic [YEAR_W-1:0]  end_year;
        logic [MONTH_W-1:0] end_month;
        logic [DAY_W-1:0]   end_day;
        logic               include_end;
    } span_req_t;

    typedef struct packed {
        logic [COUNT_W-1:0] day_count;
        logic               date_error;
    } span_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;

    span_res_t   expected_spans[$];
    int          mismatches = 0;
    int          cycles = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;

    gregorian_date_span_days uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("gregorian_date_span_days regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    // ---------------------------------------------------------------- predictor

    function automatic bit is_leap(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
        case (m)
            2:              return is_leap(y) ? 29 : 28;
            4, 6, 9, 11:    return 30;
            1, 3, 5, 7, 8,
            10, 12:         return 31;
            default:        return 0;
        endcase
    endfunction

    function automatic bit date_ok(int unsigned y, int unsigned m, int unsigned d);
        return (y >= 1) && (y <= MAX_YEAR) && (m >= 1) && (m <= 12) &&
               (d >= 1) && (d <= days_in_month(y, m));
    endfunction

    // Day 1 is 0001-01-01.
    function automatic int unsigned ordinal_day(int unsigned y, int unsigned m,
                                                int unsigned d);
        int unsigned p;
        int unsigned n;
        p = y - 1;
        n = 365 * p + p / 4 - p / 100 + p / 400;
        for (int unsigned k = 1; k < m; k++)
            n += days_in_month(y, k);
        return n + d;
    endfunction

    function automatic span_res_t predict_span(span_req_t r);
        span_res_t   res;
        int unsigned first;
        int unsigned last;
        int unsigned span;
        res = '0;
        if (!date_ok(r.start_year, r.start_month, r.start_day) ||
            !date_ok(r.end_year, r.end_month, r.end_day))
        begin
            res.date_error = 1'b1;
            return res;
        end
        first = ordinal_day(r.start_year, r.start_month, r.start_day);
        last  = ordinal_day(r.end_year, r.end_month, r.end_day);
        span  = (last > first) ? last - first : 0;
        span += r.include_end;
        if (span > COUNT_MAX)
            span = COUNT_MAX;
        res.day_count = span[COUNT_W-1:0];
        return res;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        $display("mismatch at cycle %0d: %s got %0d expected %0d",
                 cycles, what, got, want);
    endtask

    always @(posedge clk)
    begin
        span_res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_spans.size() == 0)
                report_mismatch("unexpected result beat, day_count", m_axis_tdata[21:0], 0);
            else
            begin
                want = expected_spans.pop_front();
                if (m_axis_tdata[COUNT_W-1:0] !== want.day_count)
                    report_mismatch("day_count", m_axis_tdata[COUNT_W-1:0], want.day_count);
                if (m_axis_tuser !== want.date_error)
                    report_mismatch("date_error", m_axis_tuser, want.date_error);
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic send_span(span_req_t r);
        if ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, r.include_end, r.end_day, r.end_month, r.end_year,
                          r.start_day, r.start_month, r.start_year};
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_spans.push_back(predict_span(r));
    endtask

    // Drop valid and hold off until every result beat has come back.
    task automatic wait_drained;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_spans.size() != 0)
            @(posedge clk);
    endtask

    function automatic span_req_t make_span(int sy, int sm, int sd, int ey, int em,
                                            int ed, bit inc);
        span_req_t r;
        r.start_year  = YEAR_W'(sy);
        r.start_month = MONTH_W'(sm);
        r.start_day   = DAY_W'(sd);
        r.end_year    = YEAR_W'(ey);
        r.end_month   = MONTH_W'(em);
        r.end_day     = DAY_W'(ed);
        r.include_end = inc;
        return r;
    endfunction

    function automatic span_req_t random_span();
        span_req_t   r;
        int unsigned mode;
        int unsigned len;
        int unsigned which;
        mode = $urandom_range(99);
        r.include_end = 1'($urandom_range(1));
        r.start_year  = YEAR_W'($urandom_range(9999, 1));
        r.start_month = MONTH_W'($urandom_range(12, 1));
        len = days_in_month(r.start_year, r.start_month);
        r.start_day = DAY_W'(($urandom_range(7) == 0) ? len : $urandom_range(len, 1));
        if (mode < 40)
        begin
            // nearby end date: often before the start, often within a year
            r.end_year = r.start_year;
            if ($urandom_range(1) && r.start_year < MAX_YEAR)
                r.end_year = r.start_year + YEAR_W'(1);
        end
        else
            r.end_year = YEAR_W'($urandom_range(9999, 1));
        r.end_month = MONTH_W'($urandom_range(12, 1));
        len = days_in_month(r.end_year, r.end_month);
        r.end_day = DAY_W'(($urandom_range(7) == 0) ? len : $urandom_range(len, 1));
        if (mode >= 70 && mode < 78)
        begin
            r.end_year  = r.start_year;
            r.end_month = r.start_month;
            r.end_day   = r.start_day;
        end
        else if (mode >= 78 && mode < 87)
        begin
            // break the month or the day of one date
            which = $urandom_range(3);
            len = days_in_month(r.start_year, r.start_month);
            case (which)
                0: r.start_month = MONTH_W'($urandom_range(1) ? 0
                                                              : $urandom_range(15, 13));
                1: r.start_day   = DAY_W'((len == 31 || $urandom_range(1)) ? 0
                                                                : $urandom_range(31, len + 1));
                2: r.end_month   = MONTH_W'($urandom_range(1) ? 0
                                                              : $urandom_range(15, 13));
                default:
                begin
                    len = days_in_month(r.end_year, r.end_month);
                    r.end_day = DAY_W'((len == 31 || $urandom_range(1)) ? 0
                                                         : $urandom_range(31, len + 1));
                end
            endcase
        end
        else if (mode >= 87 && mode < 94)
        begin
            if ($urandom_range(1))
                r.start_year = YEAR_W'($urandom_range(1) ? 0
                                                         : $urandom_range(16383, 10000));
            else
                r.end_year = YEAR_W'($urandom_range(1) ? 0
                                                       : $urandom_range(16383, 10000));
        end
        else if (mode >= 94)
            r = span_req_t'({$urandom, $urandom});
        return r;
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_directed;
        idle_pct  = 0;
        stall_pct = 0;
        // widest span, and its reverse
        send_span(make_span(1, 1, 1, 9999, 12, 31, 1'b1));
        send_span(make_span(1, 1, 1, 9999, 12, 31, 1'b0));
        send_span(make_span(9999, 12, 31, 1, 1, 1, 1'b0));
        send_span(make_span(9999, 12, 31, 1, 1, 1, 1'b1));
        // equal dates
        send_span(make_span(2024, 6, 15, 2024, 6, 15, 1'b0));
        send_span(make_span(2024, 6, 15, 2024, 6, 15, 1'b1));
        // leap rules: by 400, by 100, by 4, common year
        send_span(make_span(2000, 2, 28, 2000, 3, 1, 1'b0));
        send_span(make_span(1900, 2, 28, 1900, 3, 1, 1'b0));
        send_span(make_span(2000, 2, 29, 2004, 2, 29, 1'b0));
        send_span(make_span(1900, 2, 29, 1901, 1, 1, 1'b0));
        send_span(make_span(2023, 1, 1, 2023, 2, 29, 1'b1));
        send_span(make_span(2023, 12, 31, 2024, 1, 1, 1'b0));
        // invalid month or day in either date, and a valid pair of month ends
        send_span(make_span(2020, 0, 10, 2021, 1, 1, 1'b1));
        send_span(make_span(2020, 13, 10, 2021, 1, 1, 1'b0));
        send_span(make_span(2020, 1, 1, 2021, 15, 31, 1'b1));
        send_span(make_span(2020, 1, 0, 2021, 1, 1, 1'b0));
        send_span(make_span(2020, 1, 1, 2021, 4, 31, 1'b1));
        send_span(make_span(2020, 1, 31, 2021, 1, 31, 1'b1));
        // year out of range, and a short span within year 1
        send_span(make_span(0, 1, 1, 5, 1, 1, 1'b1));
        send_span(make_span(1, 1, 1, 10000, 1, 1, 1'b0));
        send_span(make_span(16383, 15, 31, 16383, 15, 31, 1'b1));
        send_span(make_span(1, 1, 1, 1, 1, 2, 1'b1));
        wait_drained();
    endtask

    task automatic run_random(int sender_idle, int receiver_stall);
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        repeat (RANDOM_ITEMS)
            send_span(random_span());
        wait_drained();
    endtask

    task automatic test_back_to_back;
        run_random(0, 0);
    endtask

    task automatic test_sender_gaps;
        run_random(83, 0);
    endtask

    task automatic test_receiver_stalls;
        run_random(0, 83);
    endtask

    task automatic test_both_idle;
        run_random(9, 9);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_back_to_back();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("gregorian_date_span_days regression: pass");
        else
            $display("gregorian_date_span_days regression: fail");
        $finish;
    end

endmodule

>>> gregorian_date_span_days.f
hdl/gdsd_pkg.sv
hdl/gdsd_day_number.sv
hdl/gregorian_date_span_days.sv
tb/sv/testbench.sv
